### sv/mup3_pkg.sv
// Shared types, widths and register codes for the 3-D max-unpool scatter address block.
`default_nettype none
package mup3_pkg;

    localparam int POS_W        = 10;
    localparam int DIM_W        = 11;
    localparam int STRIDE_W     = 8;
    localparam int OFF_W        = 8;
    localparam int VAL_W        = 32;
    localparam int OUT_ADDR_W   = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int LIMIT_W      = 17;

    // term widths, sized for the largest register and position values
    localparam int SLICE_TERM_W = POS_W + DIM_W;
    localparam int AXIS_TERM_W  = POS_W + STRIDE_W + 1;
    localparam int A_W          = SLICE_TERM_W + 1;
    localparam int B_W          = A_W + DIM_W + 1;
    localparam int P_W          = B_W + DIM_W;
    localparam int FULL_W       = P_W + 1;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_OUT_DEPTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS  = 3'd5;

    typedef struct packed {
        logic [DIM_W-1:0]    out_depth;
        logic [DIM_W-1:0]    out_rows;
        logic [DIM_W-1:0]    out_cols;
        logic [STRIDE_W-1:0] stride_depth;
        logic [STRIDE_W-1:0] stride_rows;
        logic [STRIDE_W-1:0] stride_cols;
    } t_cfg;

    // classified request: partial terms of the Horner form plus bounds error
    typedef struct packed {
        logic [SLICE_TERM_W-1:0] slice_term;
        logic [AXIS_TERM_W-1:0]  depth_term;
        logic [AXIS_TERM_W-1:0]  row_term;
        logic [AXIS_TERM_W-1:0]  col_term;
        logic [VAL_W-1:0]        value;
        logic                    err;
    } t_item;

endpackage
`default_nettype wire

### sv/mup3_front.sv
// Front end: bounds classification and first-level products of an incoming request.
`default_nettype none
module mup3_front #(
    parameter int IN_DIM_MAX = 1024,
    parameter int MAX_SLICES = 1024
) (
    input  wire mup3_pkg::t_cfg              i_cfg,
    input  wire [mup3_pkg::POS_W-1:0]        i_slice_pos,
    input  wire [mup3_pkg::POS_W-1:0]        i_depth_pos,
    input  wire [mup3_pkg::POS_W-1:0]        i_row_pos,
    input  wire [mup3_pkg::POS_W-1:0]        i_col_pos,
    input  wire [mup3_pkg::VAL_W-1:0]        i_pooled_value,
    input  wire [mup3_pkg::OFF_W-1:0]        i_offset_depth,
    input  wire [mup3_pkg::OFF_W-1:0]        i_offset_row,
    input  wire [mup3_pkg::OFF_W-1:0]        i_offset_col,
    output mup3_pkg::t_item                  o_item
);

    localparam logic [mup3_pkg::LIMIT_W-1:0] DIM_LIM   = mup3_pkg::LIMIT_W'(IN_DIM_MAX);
    localparam logic [mup3_pkg::LIMIT_W-1:0] SLICE_LIM = mup3_pkg::LIMIT_W'(MAX_SLICES);
    localparam int LPAD = mup3_pkg::LIMIT_W - mup3_pkg::POS_W;
    localparam int SW   = mup3_pkg::SLICE_TERM_W;
    localparam int AW   = mup3_pkg::AXIS_TERM_W;

    logic off_err;
    logic pos_err;

    always_comb begin
        off_err = ({3'b000, i_offset_depth} >= i_cfg.out_depth)
               || ({3'b000, i_offset_row}   >= i_cfg.out_rows)
               || ({3'b000, i_offset_col}   >= i_cfg.out_cols);
        pos_err = ({{LPAD{1'b0}}, i_slice_pos} >= SLICE_LIM)
               || ({{LPAD{1'b0}}, i_depth_pos} >= DIM_LIM)
               || ({{LPAD{1'b0}}, i_row_pos}   >= DIM_LIM)
               || ({{LPAD{1'b0}}, i_col_pos}   >= DIM_LIM);
    end

    always_comb begin
        o_item.slice_term = SW'(i_slice_pos) * SW'(i_cfg.out_depth);
        o_item.depth_term = AW'(i_depth_pos) * AW'(i_cfg.stride_depth) + AW'(i_offset_depth);
        o_item.row_term   = AW'(i_row_pos) * AW'(i_cfg.stride_rows) + AW'(i_offset_row);
        o_item.col_term   = AW'(i_col_pos) * AW'(i_cfg.stride_cols) + AW'(i_offset_col);
        o_item.value      = i_pooled_value;
        o_item.err        = off_err || pos_err;
    end

endmodule
`default_nettype wire

### sv/mup3_queue.sv
// Short register queue decoupling the front end from the address pipeline.
`default_nettype none
module mup3_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_wr,
    input  wire mup3_pkg::t_item     i_wr_data,
    output logic                     o_full,
    output logic                     o_valid,
    output mup3_pkg::t_item          o_rd_data,
    input  wire                      i_rd
);

    localparam logic [mup3_pkg::Q_PTR_W:0] DEPTH = (mup3_pkg::Q_PTR_W + 1)'(mup3_pkg::Q_DEPTH);

    mup3_pkg::t_item                 r_mem [mup3_pkg::Q_DEPTH];
    logic [mup3_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [mup3_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [mup3_pkg::Q_PTR_W:0]      r_count;
    logic [mup3_pkg::Q_PTR_W:0]      n_count;
    logic                            wr_en;
    logic                            rd_en;

    assign o_full    = (r_count == DEPTH);
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;

    always_comb begin
        n_count = r_count;
        case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd_en) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr_ptr] <= i_wr_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a write");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != DEPTH) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

### sv/mup3_back.sv
// Back end: elastic pipeline finishing the flat address, overflow check and result register.
`default_nettype none
module mup3_back #(
    parameter int ADDR_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire mup3_pkg::t_cfg              i_cfg,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire mup3_pkg::t_item             i_item,
    input  wire                              i_pop,
    output logic                             o_empty,
    output logic [mup3_pkg::OUT_ADDR_W-1:0]  o_write_address,
    output logic [mup3_pkg::VAL_W-1:0]       o_write_value,
    output logic                             o_write_enable,
    output logic                             o_index_error
);

    localparam int AW = mup3_pkg::A_W;
    localparam int BW = mup3_pkg::B_W;
    localparam int PW = mup3_pkg::P_W;
    localparam int FW = mup3_pkg::FULL_W;
    localparam int TW = mup3_pkg::AXIS_TERM_W;
    localparam int VW = mup3_pkg::VAL_W;

    // stage 1: A = slice*D + t*Sd + od
    logic          r_v1;
    logic [AW-1:0] r_a1;
    logic [TW-1:0] r_row1, r_col1;
    logic [VW-1:0] r_val1;
    logic          r_err1;
    // stage 2: A*R
    logic          r_v2;
    logic [BW-1:0] r_b2;
    logic [TW-1:0] r_row2, r_col2;
    logic [VW-1:0] r_val2;
    logic          r_err2;
    // stage 3: A*R + y*Sr + or
    logic          r_v3;
    logic [BW-1:0] r_b3;
    logic [TW-1:0] r_col3;
    logic [VW-1:0] r_val3;
    logic          r_err3;
    // stage 4: (...)*C
    logic          r_v4;
    logic [PW-1:0] r_p4;
    logic [TW-1:0] r_col4;
    logic [VW-1:0] r_val4;
    logic          r_err4;
    // stage 5: result register
    logic          r_v5;
    logic [mup3_pkg::OUT_ADDR_W-1:0] r_addr5;
    logic [VW-1:0] r_val5;
    logic          r_we5;
    logic          r_err5;

    logic          rdy1, rdy2, rdy3, rdy4, rdy5;
    logic [FW-1:0] full_addr;
    logic          ovf;
    logic          bad;

    assign rdy5    = !r_v5 || i_pop;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign full_addr = FW'(r_p4) + FW'(r_col4);
    assign ovf       = |(full_addr >> ADDR_BITS);
    assign bad       = r_err4 || ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_a1   <= AW'(i_item.slice_term) + AW'(i_item.depth_term);
            r_row1 <= i_item.row_term;
            r_col1 <= i_item.col_term;
            r_val1 <= i_item.value;
            r_err1 <= i_item.err;
        end
        if (rdy2) begin
            r_b2   <= BW'(r_a1) * BW'(i_cfg.out_rows);
            r_row2 <= r_row1;
            r_col2 <= r_col1;
            r_val2 <= r_val1;
            r_err2 <= r_err1;
        end
        if (rdy3) begin
            r_b3   <= r_b2 + BW'(r_row2);
            r_col3 <= r_col2;
            r_val3 <= r_val2;
            r_err3 <= r_err2;
        end
        if (rdy4) begin
            r_p4   <= PW'(r_b3) * PW'(i_cfg.out_cols);
            r_col4 <= r_col3;
            r_val4 <= r_val3;
            r_err4 <= r_err3;
        end
        if (rdy5) begin
            r_addr5 <= bad ? '0 : full_addr[mup3_pkg::OUT_ADDR_W-1:0];
            r_val5  <= bad ? '0 : r_val4;
            r_we5   <= !bad;
            r_err5  <= bad;
        end
    end

    assign o_empty         = !r_v5;
    assign o_write_address = r_addr5;
    assign o_write_value   = r_val5;
    assign o_write_enable  = r_we5;
    assign o_index_error   = r_err5;

`ifndef SYNTHESIS
    a_we_xor_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_we5 != r_err5))
        else $error("write enable and error both set or both clear");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_err5) |-> (r_addr5 == '0 && r_val5 == '0))
        else $error("rejected request carries nonzero payload");
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !rdy5) |=> r_v4)
        else $error("stalled stage lost its request");
`endif

endmodule
`default_nettype wire

### sv/max_unpool3d_scatter_address.sv
// Top level: configuration registers, front end, decoupling queue and address pipeline.
// Path: accepted request -> queue -> back stages 1 to 5 -> result shown with empty low.
// Throughput: one request per cycle while pop drains the output; under backpressure the
// five-stage back pipeline stalls and the four-entry front-to-back queue fills.
// Reset: synchronous active-low; clears queue and pipeline valid state and sets all
// size and stride registers to 1.
`default_nettype none
module max_unpool3d_scatter_address #(
    parameter int ADDR_BITS  = 32,
    parameter int IN_DIM_MAX = 1024,
    parameter int MAX_SLICES = 1024
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [mup3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [mup3_pkg::DIM_W-1:0]         i_cfg_data,
    input  wire                               push,
    output logic                              full,
    input  wire [mup3_pkg::POS_W-1:0]         i_slice_pos,
    input  wire [mup3_pkg::POS_W-1:0]         i_depth_pos,
    input  wire [mup3_pkg::POS_W-1:0]         i_row_pos,
    input  wire [mup3_pkg::POS_W-1:0]         i_col_pos,
    input  wire [mup3_pkg::VAL_W-1:0]         i_pooled_value,
    input  wire [mup3_pkg::OFF_W-1:0]         i_offset_depth,
    input  wire [mup3_pkg::OFF_W-1:0]         i_offset_row,
    input  wire [mup3_pkg::OFF_W-1:0]         i_offset_col,
    output logic                              empty,
    input  wire                               pop,
    output logic [mup3_pkg::OUT_ADDR_W-1:0]   o_write_address,
    output logic [mup3_pkg::VAL_W-1:0]        o_write_value,
    output logic                              o_write_enable,
    output logic                              o_index_error
);

    mup3_pkg::t_cfg  r_cfg;
    mup3_pkg::t_item front_item;
    mup3_pkg::t_item q_item;
    logic            q_valid;
    logic            back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_depth    <= 11'd1;
            r_cfg.out_rows     <= 11'd1;
            r_cfg.out_cols     <= 11'd1;
            r_cfg.stride_depth <= 8'd1;
            r_cfg.stride_rows  <= 8'd1;
            r_cfg.stride_cols  <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mup3_pkg::REG_OUT_DEPTH:    r_cfg.out_depth    <= i_cfg_data;
                mup3_pkg::REG_OUT_ROWS:     r_cfg.out_rows     <= i_cfg_data;
                mup3_pkg::REG_OUT_COLS:     r_cfg.out_cols     <= i_cfg_data;
                mup3_pkg::REG_STRIDE_DEPTH: r_cfg.stride_depth <= i_cfg_data[7:0];
                mup3_pkg::REG_STRIDE_ROWS:  r_cfg.stride_rows  <= i_cfg_data[7:0];
                mup3_pkg::REG_STRIDE_COLS:  r_cfg.stride_cols  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    mup3_front #(
        .IN_DIM_MAX (IN_DIM_MAX),
        .MAX_SLICES (MAX_SLICES)
    ) u_front (
        .i_cfg          (r_cfg),
        .i_slice_pos    (i_slice_pos),
        .i_depth_pos    (i_depth_pos),
        .i_row_pos      (i_row_pos),
        .i_col_pos      (i_col_pos),
        .i_pooled_value (i_pooled_value),
        .i_offset_depth (i_offset_depth),
        .i_offset_row   (i_offset_row),
        .i_offset_col   (i_offset_col),
        .o_item         (front_item)
    );

    mup3_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_item),
        .o_full    (full),
        .o_valid   (q_valid),
        .o_rd_data (q_item),
        .i_rd      (back_ready)
    );

    mup3_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (q_valid),
        .o_ready         (back_ready),
        .i_item          (q_item),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_write_enable  (o_write_enable),
        .o_index_error   (o_index_error)
    );

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for max_unpool3d_scatter_address: directed table, then shaped random.
module testbench;

    localparam int ADDR_BITS   = 32;
    localparam int IN_DIM_MAX  = 1024;
    localparam int MAX_SLICES  = 1024;
    localparam int PIPE_LAT    = 5;
    localparam int STALL_LIMIT = 2000;

    localparam int POS_W       = mup3_pkg::POS_W;
    localparam int DIM_W       = mup3_pkg::DIM_W;
    localparam int STRIDE_W    = mup3_pkg::STRIDE_W;
    localparam int OFF_W       = mup3_pkg::OFF_W;
    localparam int VAL_W       = mup3_pkg::VAL_W;
    localparam int OUT_ADDR_W  = mup3_pkg::OUT_ADDR_W;
    localparam int CFG_IDX_W   = mup3_pkg::CFG_IDX_W;

    // indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] slice;
        logic [POS_W-1:0] depth;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic [OFF_W-1:0] od;
        logic [OFF_W-1:0] orow;
        logic [OFF_W-1:0] ocol;
    } t_pool_elem;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [VAL_W-1:0]      value;
        logic                  we;
        logic                  err;
    } t_wr_cmd;

    typedef enum logic { ROW_CFG, ROW_ELEM } t_row_kind;
    typedef enum int { CK_SMALL, CK_WIDE, CK_MAX, CK_ZERO_DIM, CK_UNIT } t_cfg_kind;
    typedef enum int { RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC } t_rx_mode;

    typedef struct {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [DIM_W-1:0]        data;
        t_pool_elem              elem;
        bit                      has_exp;
        t_wr_cmd                 exp;
    } t_stim_row;

    localparam t_wr_cmd WR_REJECT = '{addr: '0, value: '0, we: 1'b0, err: 1'b1};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DIM_W-1:0]      i_cfg_data;
    logic                  push;
    logic                  full;
    logic                  empty;
    logic                  pop;
    t_pool_elem            drv_elem;
    logic [OUT_ADDR_W-1:0] o_write_address;
    logic [VAL_W-1:0]      o_write_value;
    logic                  o_write_enable;
    logic                  o_index_error;

    mup3_pkg::t_cfg cfg_model;
    t_wr_cmd    pending_writes[$];
    t_stim_row  rows[$];
    int         err_count = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;
    int         rx_left = 0;
    t_rx_mode   rx_mode = RX_STEADY;
    bit         exp_given;
    t_wr_cmd    exp_typed;

    max_unpool3d_scatter_address #(
        .ADDR_BITS  (ADDR_BITS),
        .IN_DIM_MAX (IN_DIM_MAX),
        .MAX_SLICES (MAX_SLICES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_slice_pos     (drv_elem.slice),
        .i_depth_pos     (drv_elem.depth),
        .i_row_pos       (drv_elem.row),
        .i_col_pos       (drv_elem.col),
        .i_pooled_value  (drv_elem.value),
        .i_offset_depth  (drv_elem.od),
        .i_offset_row    (drv_elem.orow),
        .i_offset_col    (drv_elem.ocol),
        .empty           (empty),
        .pop             (pop),
        .o_write_address (o_write_address),
        .o_write_value   (o_write_value),
        .o_write_enable  (o_write_enable),
        .o_index_error   (o_index_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_wr_cmd scatter_addr_predict(t_pool_elem e, mup3_pkg::t_cfg c);
        longint unsigned s, t, y, x, od, orw, oc;
        longint unsigned dd, rr, cc, sd, sr, sc, plane, addr;
        logic            bad;
        t_wr_cmd         w;
        s = 64'(e.slice); t = 64'(e.depth); y = 64'(e.row); x = 64'(e.col);
        od = 64'(e.od); orw = 64'(e.orow); oc = 64'(e.ocol);
        dd = 64'(c.out_depth); rr = 64'(c.out_rows); cc = 64'(c.out_cols);
        sd = 64'(c.stride_depth); sr = 64'(c.stride_rows); sc = 64'(c.stride_cols);
        plane = rr * cc;
        bad = (od >= dd) || (orw >= rr) || (oc >= cc);
        bad = bad || (s >= 64'(MAX_SLICES)) || (t >= 64'(IN_DIM_MAX))
              || (y >= 64'(IN_DIM_MAX)) || (x >= 64'(IN_DIM_MAX));
        addr = s * dd * plane + (t * sd + od) * plane + (y * sr + orw) * cc + (x * sc + oc);
        if (addr >= (64'd1 << ADDR_BITS))
            bad = 1'b1;
        if (bad) begin
            w = WR_REJECT;
        end else begin
            w.addr  = addr[OUT_ADDR_W-1:0];
            w.value = e.value;
            w.we    = 1'b1;
            w.err   = 1'b0;
        end
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic check_write(t_wr_cmd want);
        if (o_write_address !== want.addr)
            report_mismatch($sformatf("write_address got %h want %h", o_write_address,
                                      want.addr));
        if (o_write_value !== want.value)
            report_mismatch($sformatf("write_value got %h want %h", o_write_value,
                                      want.value));
        if (o_write_enable !== want.we)
            report_mismatch($sformatf("write_enable got %b want %b", o_write_enable,
                                      want.we));
        if (o_index_error !== want.err)
            report_mismatch($sformatf("index_error got %b want %b", o_index_error,
                                      want.err));
    endtask

    // register model, scoreboard and stall watchdog, all sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            cfg_model = '{out_depth: 11'd1, out_rows: 11'd1, out_cols: 11'd1,
                          stride_depth: 8'd1, stride_rows: 8'd1, stride_cols: 8'd1};
        end else begin
            if (push && !full) begin
                pending_writes.push_back(exp_given ? exp_typed
                                                   : scatter_addr_predict(drv_elem, cfg_model));
                moved = 1'b1;
            end
            if (pop && !empty) begin
                moved = 1'b1;
                if (pending_writes.size() == 0)
                    report_mismatch($sformatf("result with nothing pending, addr %h",
                                              o_write_address));
                else
                    check_write(pending_writes.pop_front());
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mup3_pkg::REG_OUT_DEPTH:    cfg_model.out_depth    = i_cfg_data;
                    mup3_pkg::REG_OUT_ROWS:     cfg_model.out_rows     = i_cfg_data;
                    mup3_pkg::REG_OUT_COLS:     cfg_model.out_cols     = i_cfg_data;
                    mup3_pkg::REG_STRIDE_DEPTH:
                        cfg_model.stride_depth = i_cfg_data[STRIDE_W-1:0];
                    mup3_pkg::REG_STRIDE_ROWS:
                        cfg_model.stride_rows  = i_cfg_data[STRIDE_W-1:0];
                    mup3_pkg::REG_STRIDE_COLS:
                        cfg_model.stride_cols  = i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // receiver: switches between steady, random and periodic pop patterns
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = int'($urandom_range(30, 300));
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY:   pop <= 1'b1;
            RX_MOSTLY:   pop <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   pop <= ($urandom_range(0, 4) == 0);
            default:     pop <= rx_left[2];
        endcase
    end

    function automatic t_pool_elem mk_elem(int s, int t, int y, int x, logic [31:0] v,
                                           int od, int orw, int oc);
        t_pool_elem e;
        e.slice = POS_W'(s); e.depth = POS_W'(t); e.row = POS_W'(y); e.col = POS_W'(x);
        e.value = v; e.od = OFF_W'(od); e.orow = OFF_W'(orw); e.ocol = OFF_W'(oc);
        return e;
    endfunction

    function automatic t_wr_cmd wr_ok(logic [31:0] addr, logic [31:0] v);
        t_wr_cmd w;
        w.addr = addr; w.value = v; w.we = 1'b1; w.err = 1'b0;
        return w;
    endfunction

    task automatic add_cfg_row(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        t_stim_row r;
        r.kind = ROW_CFG; r.idx = idx; r.data = data;
        r.elem = '0; r.has_exp = 1'b0; r.exp = WR_REJECT;
        rows.push_back(r);
    endtask

    task automatic add_elem_row(t_pool_elem e, bit has_exp, t_wr_cmd exp);
        t_stim_row r;
        r.kind = ROW_ELEM; r.idx = '0; r.data = '0;
        r.elem = e; r.has_exp = has_exp; r.exp = exp;
        rows.push_back(r);
    endtask

    // skewed toward small positions so that addresses often fit
    function automatic logic [POS_W-1:0] pick_pos();
        return POS_W'($urandom_range(0, 1023) >> $urandom_range(0, 10));
    endfunction

    function automatic logic [OFF_W-1:0] pick_off(logic [DIM_W-1:0] dim);
        int lim;
        if (dim == 0)
            return OFF_W'($urandom);
        lim = (dim > 11'd256) ? 256 : int'(dim);
        return OFF_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [OFF_W-1:0] bad_off(logic [DIM_W-1:0] dim);
        if (dim > 11'd255)
            return OFF_W'($urandom);
        return OFF_W'($urandom_range(32'(dim), 255));
    endfunction

    function automatic t_pool_elem gen_elem();
        t_pool_elem e;
        int         r;
        r = int'($urandom_range(0, 99));
        e.value = $urandom;
        if ($urandom_range(0, 15) == 0)
            e.value = $urandom_range(0, 1) ? '1 : '0;
        if (r < 15) begin
            e.slice = POS_W'($urandom); e.depth = POS_W'($urandom);
            e.row = POS_W'($urandom); e.col = POS_W'($urandom);
            e.od = OFF_W'($urandom); e.orow = OFF_W'($urandom); e.ocol = OFF_W'($urandom);
        end else begin
            e.slice = pick_pos(); e.depth = pick_pos(); e.row = pick_pos(); e.col = pick_pos();
            e.od   = pick_off(cfg_model.out_depth);
            e.orow = pick_off(cfg_model.out_rows);
            e.ocol = pick_off(cfg_model.out_cols);
            if (r >= 85) begin
                case ($urandom_range(0, 2))
                    0:       e.od   = bad_off(cfg_model.out_depth);
                    1:       e.orow = bad_off(cfg_model.out_rows);
                    default: e.ocol = bad_off(cfg_model.out_cols);
                endcase
            end
        end
        return e;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // bursts of random length, random gaps between them
    task automatic send_elem(t_pool_elem e, bit has_exp, t_wr_cmd exp);
        int gap;
        if (burst_left == 0) begin
            burst_left = int'($urandom_range(1, 40));
            gap = int'($urandom_range(0, 10));
            if (gap > 0) begin
                push = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        drv_elem  = e;
        exp_given = has_exp;
        exp_typed = exp;
        push      = 1'b1;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic drain_pending();
        push = 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(negedge i_clk);
    endtask

    task automatic apply_config(t_cfg_kind kind);
        logic [DIM_W-1:0] dd, rr, cc, sd, sr, sc;
        dd = DIM_W'($urandom_range(1, 16)); rr = DIM_W'($urandom_range(1, 16));
        cc = DIM_W'($urandom_range(1, 16));
        sd = DIM_W'($urandom_range(1, 4));  sr = DIM_W'($urandom_range(1, 4));
        sc = DIM_W'($urandom_range(1, 4));
        case (kind)
            CK_WIDE: begin
                dd = DIM_W'($urandom_range(1, 2047)); rr = DIM_W'($urandom_range(1, 2047));
                cc = DIM_W'($urandom_range(1, 2047));
                sd = DIM_W'($urandom); sr = DIM_W'($urandom); sc = DIM_W'($urandom);
            end
            CK_MAX: begin
                dd = '1; rr = '1; cc = '1; sd = '1; sr = '1; sc = '1;
            end
            CK_ZERO_DIM: begin
                case ($urandom_range(0, 2))
                    0:       dd = '0;
                    1:       rr = '0;
                    default: cc = '0;
                endcase
            end
            CK_UNIT: begin
                dd = DIM_W'(1); rr = DIM_W'(1); cc = DIM_W'(1);
                sd = DIM_W'(1); sr = DIM_W'(1); sc = DIM_W'(1);
            end
            default: ;
        endcase
        cfg_write(mup3_pkg::REG_OUT_DEPTH, dd);
        cfg_write(mup3_pkg::REG_OUT_ROWS, rr);
        cfg_write(mup3_pkg::REG_OUT_COLS, cc);
        cfg_write(mup3_pkg::REG_STRIDE_DEPTH, sd);
        cfg_write(mup3_pkg::REG_STRIDE_ROWS, sr);
        cfg_write(mup3_pkg::REG_STRIDE_COLS, sc);
        if (kind == CK_MAX) begin
            cfg_write(REG_SPARE_6, DIM_W'($urandom));
            cfg_write(REG_SPARE_7, DIM_W'($urandom));
        end
    endtask

    initial begin : stimulus
        t_cfg_kind plan [10];
        plan        = '{CK_SMALL, CK_WIDE, CK_MAX, CK_SMALL, CK_ZERO_DIM,
                        CK_WIDE, CK_UNIT, CK_SMALL, CK_WIDE, CK_SMALL};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        push        = 1'b0;
        drv_elem    = '0;
        exp_given   = 1'b0;
        exp_typed   = WR_REJECT;

        // reset sizes and strides are all 1
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h0, 0, 0, 0), 1, wr_ok(32'd0, 32'h0));
        add_elem_row(mk_elem(0, 0, 0, 0, '1, 0, 0, 0), 1, wr_ok(32'd0, '1));
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h1234_5678, 1, 0, 0), 1, WR_REJECT);
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h1234_5678, 0, 1, 0), 1, WR_REJECT);
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h1234_5678, 0, 0, 1), 1, WR_REJECT);
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h1234_5678, 255, 255, 255), 1, WR_REJECT);
        add_elem_row(mk_elem(1023, 1023, 1023, 1023, 32'hA5A5_A5A5, 0, 0, 0), 1,
                     wr_ok(32'd4092, 32'hA5A5_A5A5));
        add_elem_row(mk_elem(2, 3, 4, 5, 32'hDEAD_BEEF, 0, 0, 0), 0, WR_REJECT);
        // largest sizes; stride data above bit 7 is dropped
        add_cfg_row(mup3_pkg::REG_OUT_DEPTH, '1);
        add_cfg_row(mup3_pkg::REG_OUT_ROWS, '1);
        add_cfg_row(mup3_pkg::REG_OUT_COLS, '1);
        add_cfg_row(mup3_pkg::REG_STRIDE_DEPTH, '1);
        add_cfg_row(mup3_pkg::REG_STRIDE_ROWS, '1);
        add_cfg_row(mup3_pkg::REG_STRIDE_COLS, '1);
        add_elem_row(mk_elem(1023, 1023, 1023, 1023, 32'h5A5A_5A5A, 0, 0, 0), 1, WR_REJECT);
        add_elem_row(mk_elem(0, 0, 0, 0, 32'hFFFF_0000, 255, 255, 255), 0, WR_REJECT);
        add_elem_row(mk_elem(1, 0, 0, 0, 32'h0000_FFFF, 0, 0, 0), 0, WR_REJECT);
        add_elem_row(mk_elem(0, 3, 5, 7, 32'hC001_D00D, 1, 2, 3), 0, WR_REJECT);
        // zero depth rejects everything
        add_cfg_row(mup3_pkg::REG_OUT_DEPTH, '0);
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h0BAD_F00D, 0, 0, 0), 1, WR_REJECT);
        // zero strides, written with only bit 8 set
        add_cfg_row(mup3_pkg::REG_OUT_DEPTH, 11'd4);
        add_cfg_row(mup3_pkg::REG_OUT_ROWS, 11'd4);
        add_cfg_row(mup3_pkg::REG_OUT_COLS, 11'd4);
        add_cfg_row(mup3_pkg::REG_STRIDE_DEPTH, 11'h100);
        add_cfg_row(mup3_pkg::REG_STRIDE_ROWS, 11'h100);
        add_cfg_row(mup3_pkg::REG_STRIDE_COLS, 11'h100);
        add_elem_row(mk_elem(1023, 1023, 1023, 1023, 32'h8000_0001, 3, 3, 3), 0, WR_REJECT);
        add_elem_row(mk_elem(5, 9, 0, 2, 32'h7FFF_FFFE, 0, 1, 2), 0, WR_REJECT);
        // writes past the last register leave the setup alone
        add_cfg_row(REG_SPARE_6, '1);
        add_cfg_row(REG_SPARE_7, '0);
        add_elem_row(mk_elem(7, 1, 2, 3, 32'h1357_9BDF, 1, 1, 1), 0, WR_REJECT);
        add_elem_row(mk_elem(0, 0, 0, 0, 32'h2468_ACE0, 4, 0, 0), 1, WR_REJECT);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                if (i == 0 || rows[i-1].kind == ROW_ELEM)
                    drain_pending();
                cfg_write(rows[i].idx, rows[i].data);
            end else begin
                send_elem(rows[i].elem, rows[i].has_exp, rows[i].exp);
            end
        end

        foreach (plan[p]) begin
            drain_pending();
            apply_config(plan[p]);
            repeat ((plan[p] == CK_ZERO_DIM) ? 40 : 200)
                send_elem(gen_elem(), 1'b0, WR_REJECT);
        end

        drain_pending();
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### sim.f
sv/mup3_pkg.sv
sv/mup3_front.sv
sv/mup3_queue.sv
sv/mup3_back.sv
sv/max_unpool3d_scatter_address.sv
verif/testbench.sv
